@@ rtl/core/bba_pkg.sv @@
// bitmap block allocator: shared types, codes and constants
// no dependencies
package bba_pkg;

  localparam int unsigned HDR_BYTES = 2;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BS_W = 17;
  localparam int unsigned SIZE_W = 24;
  localparam int unsigned CNT_W = 9;
  localparam logic [BS_W-1:0] BS_MIN = 17'd4;
  localparam logic [BS_W-1:0] BS_MAX = 17'd65536;
  localparam logic [BS_W-1:0] BS_RESET = 17'd64;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_OUT_OF_HEAP = 2'd3
  } status_t;

  typedef enum logic {
    REG_HEAP_BASE = 1'b0,
    REG_BLOCK_SIZE = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DIV,
    S_A_CHECK,
    S_A_SCAN,
    S_A_MARK,
    S_A_MUL,
    S_F_LEN,
    S_F_CHECK,
    S_F_CLEAR,
    S_DONE
  } fsm_t;

  // result word
  typedef struct packed {
    logic [CNT_W-1:0] blocks_count;
    logic [ADDR_W-1:0] result_address;
    status_t status;
  } res_t;

  // map port request
  typedef struct packed {
    logic we;
    logic wdata;
  } map_ctl_t;

endpackage

@@ rtl/core/bba_divider.sv @@
// bitmap block allocator: restoring divider, one quotient bit a cycle
// depends on bba_pkg
module bba_divider import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [BS_W-1:0]   divisor,
  output logic              done,
  output logic [ADDR_W-1:0] quotient
);

  logic [ADDR_W-1:0] q_r, q_nxt;
  logic [BS_W:0] rem_r, rem_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [BS_W:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[BS_W-1:0], q_r[ADDR_W-1]};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'(ADDR_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt = {q_r[ADDR_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[ADDR_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign quotient = q_nxt;

endmodule

@@ rtl/core/bba_used_map.sv @@
// bitmap block allocator: used-bit memory, registered read
// depends on bba_pkg
module bba_used_map import bba_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW = 8
) (
  input  logic          clk,
  input  map_ctl_t      ctl,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) mem[waddr] <= ctl.wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bba_len_ram.sv @@
// bitmap block allocator: run length memory, registered read
// depends on bba_pkg
module bba_len_ram import bba_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW = 8,
  parameter int unsigned LW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [LW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [LW-1:0] rdata
);

  logic [LW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bitmap_block_allocator_unit.sv @@
// Bitmap next-fit block allocator over NUM_BLOCKS fixed blocks. After reset a clearing
// pass frees the used map; no word is taken meanwhile.
// An allocate runs the size division, then checks each candidate position and tests
// its blocks in the used map (one map read per cycle), then marks the run and
// computes the address with a shift-add multiply. A free runs the index division,
// reads the run length, then checks and clears the run. The used-map port (one bit
// per cycle) and the shared serial divider bound the speed of both. The result word
// is offered the cycle after the last step and held until taken; only then is the
// next word taken.
// Configuration is taken only while idle with no word offered.
// Depends on bba_pkg, bba_divider, bba_used_map, bba_len_ram.
module bitmap_block_allocator_unit import bba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // alloc_size[23:0], free_address[55:24]
  input  logic        in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // status[1:0], result_address[33:2], blocks_count[42:34]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned AW = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned PW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LW = PW;
  localparam logic [PW-1:0] NB = PW'(NUM_BLOCKS);

  fsm_t st_r, st_nxt;
  logic [ADDR_W-1:0] base_r;
  logic [BS_W-1:0] bsz_r, bs_eff;
  logic mode_r;
  logic [PW-1:0] ptr_r, ptr_nxt, n_r, n_nxt, pos_r, pos_nxt, k_r, k_nxt;
  logic wrapped_r, wrapped_nxt;
  logic [PW-1:0] clr_r;
  res_t res_r, res_nxt;
  logic [ADDR_W+BS_W-1:0] mul_acc_r;
  logic [ADDR_W-1:0] mul_a_r;
  logic [BS_W-1:0] mul_b_r;
  logic [5:0] mul_cnt_r;
  logic [ADDR_W-1:0] idx_r;

  logic div_start, div_done;
  logic [ADDR_W-1:0] div_dividend, div_q;
  map_ctl_t mctl;
  logic [AW-1:0] mwaddr, mraddr, lraddr;
  logic mrdata, lwe;
  logic [LW-1:0] lrdata;
  logic rd_pend_r;
  logic [PW:0] end_pos;
  logic [PW-1:0] wrap_lim;

  assign bs_eff = (bsz_r < BS_MIN) ? BS_MIN : ((bsz_r > BS_MAX) ? BS_MAX : bsz_r);

  bba_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(bs_eff), .done(div_done), .quotient(div_q)
  );

  bba_used_map #(.DEPTH(NUM_BLOCKS), .AW(AW)) u_map (
    .clk(clk), .ctl(mctl), .waddr(mwaddr), .raddr(mraddr), .rdata(mrdata)
  );

  bba_len_ram #(.DEPTH(NUM_BLOCKS), .AW(AW), .LW(LW)) u_len (
    .clk(clk), .we(lwe), .waddr(pos_r[AW-1:0]), .wdata(n_r),
    .raddr(lraddr), .rdata(lrdata)
  );

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_DONE);
  assign out_tdata = {5'd0, res_r};
  assign cfg_ready = (st_r == S_IDLE) && !in_tvalid;

  // map read address: current block of the run under test
  logic [PW:0] cur;
  assign cur = {1'b0, pos_r} + {1'b0, k_nxt};
  assign mraddr = cur[AW-1:0];
  // quotient holds after the division, so the length read starts on its last cycle
  assign lraddr = div_q[AW-1:0];
  assign end_pos = {1'b0, pos_r} + {1'b0, n_r};
  assign wrap_lim = wrapped_r ? ptr_r : NB;

  always_comb begin
    st_nxt = st_r;
    ptr_nxt = ptr_r;
    n_nxt = n_r;
    pos_nxt = pos_r;
    k_nxt = k_r;
    wrapped_nxt = wrapped_r;
    res_nxt = res_r;
    case (st_r)
      S_CLEAR: if (clr_r == NB - PW'(1)) st_nxt = S_IDLE;
      S_IDLE: if (in_tvalid) begin
        st_nxt = S_DIV;
        k_nxt = '0;
        res_nxt = '{blocks_count: '0, result_address: '0, status: ST_OK};
      end
      S_DIV: if (div_done) begin
        if (!mode_r) begin
          if (div_q >= ADDR_W'(NUM_BLOCKS)) begin
            res_nxt.status = ST_NO_SPACE;
            st_nxt = S_DONE;
          end else begin
            n_nxt = PW'(div_q) + PW'(1);
            pos_nxt = ptr_r;
            wrapped_nxt = 1'b0;
            k_nxt = '0;
            st_nxt = S_A_CHECK;
          end
        end else if (div_q >= ADDR_W'(NUM_BLOCKS)) begin
          res_nxt.status = ST_OUT_OF_HEAP;
          st_nxt = S_DONE;
        end else begin
          pos_nxt = PW'(div_q);
          k_nxt = '0;
          st_nxt = S_F_LEN;
        end
      end
      S_A_CHECK: begin
        // candidate pos_r must satisfy pos < limit and pos + n <= NUM_BLOCKS
        if (pos_r >= wrap_lim || end_pos > {1'b0, NB}) begin
          if (!wrapped_r) begin
            wrapped_nxt = 1'b1;
            pos_nxt = '0;
            k_nxt = '0;
          end else begin
            res_nxt.status = ST_NO_SPACE;
            st_nxt = S_DONE;
          end
        end else begin
          k_nxt = '0;
          st_nxt = S_A_SCAN;
        end
      end
      S_A_SCAN: if (rd_pend_r) begin
        if (mrdata) begin
          pos_nxt = pos_r + n_r;
          k_nxt = '0;
          st_nxt = S_A_CHECK;
        end else if (k_r == n_r - PW'(1)) begin
          k_nxt = '0;
          st_nxt = S_A_MARK;
        end else k_nxt = k_r + PW'(1);
      end
      S_A_MARK: begin
        if (k_r == n_r - PW'(1)) begin
          ptr_nxt = end_pos[PW-1:0];
          res_nxt.blocks_count = CNT_W'(n_r);
          st_nxt = S_A_MUL;
        end else k_nxt = k_r + PW'(1);
      end
      S_A_MUL: if (mul_cnt_r == 6'd0) begin
        res_nxt.result_address = base_r + mul_acc_r[ADDR_W-1:0] + ADDR_W'(HDR_BYTES);
        st_nxt = S_DONE;
      end
      S_F_LEN: if (rd_pend_r) begin
        pos_nxt = PW'(idx_r);
        n_nxt = (lrdata > NB - PW'(idx_r)) ? NB - PW'(idx_r) : lrdata;
        k_nxt = '0;
        st_nxt = S_F_CHECK;
        if (n_nxt == '0) st_nxt = S_DONE;
      end
      S_F_CHECK: if (rd_pend_r) begin
        if (!mrdata) begin
          res_nxt.status = ST_DOUBLE_FREE;
          st_nxt = S_DONE;
        end else if (k_r == n_r - PW'(1)) begin
          k_nxt = '0;
          st_nxt = S_F_CLEAR;
        end else k_nxt = k_r + PW'(1);
      end
      S_F_CLEAR: begin
        if (k_r == n_r - PW'(1)) begin
          res_nxt.blocks_count = CNT_W'(n_r);
          st_nxt = S_DONE;
        end else k_nxt = k_r + PW'(1);
      end
      S_DONE: if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mctl = '{we: 1'b0, wdata: 1'b0};
    mwaddr = cur[AW-1:0];
    lwe = 1'b0;
    div_start = 1'b0;
    div_dividend = '0;
    case (st_r)
      S_CLEAR: begin
        mctl = '{we: 1'b1, wdata: 1'b0};
        mwaddr = clr_r[AW-1:0];
      end
      S_IDLE: begin
        div_start = in_tvalid;
        // allocate: (size+2-1)/bs gives n-1; free: block index
        div_dividend = in_tuser ? (in_tdata[55:24] - ADDR_W'(HDR_BYTES) - base_r)
                                : (ADDR_W'(in_tdata[23:0]) + ADDR_W'(HDR_BYTES - 1));
      end
      S_A_MARK: begin
        mctl = '{we: 1'b1, wdata: 1'b1};
        mwaddr = AW'({1'b0, pos_r} + {1'b0, k_r});
        lwe = (k_r == '0);
      end
      S_F_CLEAR: begin
        mctl = '{we: 1'b1, wdata: 1'b0};
        mwaddr = AW'({1'b0, pos_r} + {1'b0, k_r});
      end
      default: ;
    endcase
  end

  // a map read issued this cycle is valid next cycle
  logic rd_issue;
  assign rd_issue = (st_nxt == S_A_SCAN) || (st_nxt == S_F_CHECK) ||
                    (st_nxt == S_F_LEN);

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_tvalid) mode_r <= in_tuser;
    if (st_r == S_DIV && div_done) idx_r <= div_q;
    res_r <= res_nxt;
    n_r <= n_nxt;
    pos_r <= pos_nxt;
    k_r <= k_nxt;
    wrapped_r <= wrapped_nxt;
    // shift-add multiply pos*bs, one bit a cycle
    if (st_r == S_A_MARK && st_nxt == S_A_MUL) begin
      mul_acc_r <= '0;
      mul_a_r <= ADDR_W'(pos_r);
      mul_b_r <= bs_eff;
      mul_cnt_r <= 6'(BS_W);
    end else if (st_r == S_A_MUL && mul_cnt_r != 6'd0) begin
      if (mul_b_r[0]) mul_acc_r <= mul_acc_r + (ADDR_W+BS_W)'(mul_a_r);
      mul_a_r <= {mul_a_r[ADDR_W-2:0], 1'b0};
      mul_b_r <= mul_b_r >> 1;
      mul_cnt_r <= mul_cnt_r - 6'd1;
    end
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      ptr_r <= '0;
      base_r <= '0;
      bsz_r <= BS_RESET;
      rd_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ptr_r <= ptr_nxt;
      rd_pend_r <= rd_issue && !(rd_pend_r && st_nxt == st_r && k_nxt == k_r);
      if (st_r == S_CLEAR) clr_r <= clr_r + PW'(1);
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_HEAP_BASE: base_r <= cfg_data;
          REG_BLOCK_SIZE: bsz_r <= cfg_data[BS_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/core/bba_checker.sv @@
// bitmap block allocator: port-level checks, bound to the top level
// depends on bba_pkg and bitmap_block_allocator_unit
module bba_checker import bba_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result waits");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[42:2] == '0)
    else $error("failed request carries an address or count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready stayed high after a word was taken");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
